[hdl/lkvc_pkg.sv]
package lkvc_pkg;

    // store geometry
    localparam int ENTRIES  = 16;
    localparam int KEY_BITS = 32;

    // field widths fixed by the interface
    localparam int DATA_W = 32;
    localparam int CAP_W  = 5;

    // derived widths
    localparam int IDX_W  = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int RANK_W = IDX_W;
    localparam int LIM_W  = RANK_W + 1;
    localparam int CNT_W  = $clog2(ENTRIES + 1);

    // capacity register value after reset
    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    // value returned on a miss and on every put
    localparam logic [DATA_W-1:0] MISS_VALUE = '1;

    // commands from the controller to the datapath
    typedef struct packed {
        logic accept;
        logic look;
        logic commit;
    } t_lkvc_cmd;

    // request key as stored: sign-extended, then cut to the key width
    function automatic logic [KEY_BITS-1:0] fit_key(input logic [DATA_W-1:0] k);
        logic [63:0] ext;
        ext = {{32{k[DATA_W-1]}}, k};
        return ext[KEY_BITS-1:0];
    endfunction

endpackage

[hdl/lkvc_ctrl.sv]
module lkvc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_req_valid,
    output logic                 o_req_ready,
    output logic                 o_res_valid,
    input  logic                 i_res_ready,
    output lkvc_pkg::t_lkvc_cmd  o_cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_LOOK = 2'd1;
    localparam logic [1:0] S_UPDT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;
    logic       accept;
    logic       commit;

    // result register can take a new item this cycle
    assign out_free = !r_out_valid || i_res_ready;

    // next state and commands
    always_comb begin
        n_state = r_state;
        accept  = 1'b0;
        commit  = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    accept  = 1'b1;
                    n_state = S_LOOK;
                end
            end
            S_LOOK: begin
                n_state = S_UPDT;
            end
            S_UPDT: begin
                if (out_free) begin
                    commit = 1'b1;
                    if (i_req_valid) begin
                        accept  = 1'b1;
                        n_state = S_LOOK;
                    end else begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // result valid flag
    always_comb begin
        n_out_valid = r_out_valid;
        if (commit) begin
            n_out_valid = 1'b1;
        end else if (r_out_valid && i_res_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_req_ready  = (r_state == S_IDLE) || ((r_state == S_UPDT) && out_free);
    assign o_res_valid  = r_out_valid;
    assign o_cmd.accept = accept;
    assign o_cmd.look   = (r_state == S_LOOK);
    assign o_cmd.commit = commit;

endmodule

[hdl/lkvc_dpath.sv]
module lkvc_dpath (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lkvc_pkg::t_lkvc_cmd                 i_cmd,
    input  logic                                i_cfg_we,
    input  logic        [lkvc_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic                                i_req_type,
    input  logic signed [lkvc_pkg::DATA_W-1:0]  i_req_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0]  i_req_value,
    output logic                                o_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0]  o_read_value
);

    localparam int N  = lkvc_pkg::ENTRIES;
    localparam int KW = lkvc_pkg::KEY_BITS;
    localparam int DW = lkvc_pkg::DATA_W;
    localparam int IW = lkvc_pkg::IDX_W;
    localparam int RW = lkvc_pkg::RANK_W;
    localparam int LW = lkvc_pkg::LIM_W;
    localparam int CW = lkvc_pkg::CNT_W;

    // entry store
    logic [KW-1:0] r_keys   [N];
    logic [DW-1:0] r_values [N];
    logic [RW-1:0] r_rank   [N];
    logic [N-1:0]  r_valid;
    logic [CW-1:0] r_occ;
    logic [lkvc_pkg::CAP_W-1:0] r_cap;

    // request held for the lookup and update
    logic          r_req_put;
    logic [KW-1:0] r_req_key;
    logic [DW-1:0] r_req_value;

    // lookup results
    logic          r_l_hit;
    logic [IW-1:0] r_l_slot;
    logic [LW-1:0] r_l_limit;
    logic          r_l_apply;
    logic          r_l_wr_key;
    logic          r_l_grow;
    logic [DW-1:0] r_l_rdv;

    logic          n_hit;
    logic [IW-1:0] n_hit_idx;
    logic [IW-1:0] n_free_idx;
    logic [IW-1:0] n_victim_idx;
    logic [IW-1:0] n_slot;
    logic          n_full;
    logic [31:0]   eff_cap;
    logic [31:0]   cap32;

    // output register
    logic          r_out_hit;
    logic [DW-1:0] r_out_value;

    // effective capacity and full test
    assign cap32   = 32'(r_cap);
    assign eff_cap = (cap32 == 32'd0) ? 32'd1 : ((cap32 > N) ? 32'(N) : cap32);
    assign n_full  = (32'(r_occ) >= eff_cap);

    // key match, first free entry and least recent entry
    always_comb begin
        n_hit        = 1'b0;
        n_hit_idx    = '0;
        n_free_idx   = '0;
        n_victim_idx = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (r_valid[i] && (r_keys[i] == r_req_key)) begin
                n_hit     = 1'b1;
                n_hit_idx = IW'(i);
            end
            if (!r_valid[i]) begin
                n_free_idx = IW'(i);
            end
            if (r_valid[i] && (32'(r_rank[i]) == (32'(r_occ) - 32'd1))) begin
                n_victim_idx = IW'(i);
            end
        end
        if (n_hit) begin
            n_slot = n_hit_idx;
        end else if (n_full) begin
            n_slot = n_victim_idx;
        end else begin
            n_slot = n_free_idx;
        end
    end

    // request capture
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_req_put   <= i_req_type;
            r_req_key   <= lkvc_pkg::fit_key(i_req_key);
            r_req_value <= i_req_value;
        end
    end

    // lookup register
    always_ff @(posedge i_clk) begin
        if (i_cmd.look) begin
            r_l_hit    <= n_hit;
            r_l_slot   <= n_slot;
            r_l_limit  <= n_hit ? {1'b0, r_rank[n_hit_idx]} : LW'(N);
            r_l_apply  <= n_hit || r_req_put;
            r_l_wr_key <= !n_hit && r_req_put;
            r_l_grow   <= !n_hit && r_req_put && !n_full;
            r_l_rdv    <= (n_hit && !r_req_put) ? r_values[n_hit_idx] : lkvc_pkg::MISS_VALUE;
        end
    end

    // recency, valid bits, occupancy and capacity
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_occ   <= '0;
            r_cap   <= lkvc_pkg::CAP_RESET;
            for (int i = 0; i < N; i++) begin
                r_rank[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_data;
            end
            if (i_cmd.commit && r_l_apply) begin
                for (int i = 0; i < N; i++) begin
                    if (IW'(i) == r_l_slot) begin
                        r_rank[i]  <= '0;
                        r_valid[i] <= 1'b1;
                    end else if (r_valid[i] && ({1'b0, r_rank[i]} < r_l_limit)) begin
                        r_rank[i] <= r_rank[i] + RW'(1);
                    end
                end
            end
            if (i_cmd.commit && r_l_grow) begin
                r_occ <= r_occ + CW'(1);
            end
        end
    end

    // key and value store
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit && r_l_wr_key) begin
            r_keys[r_l_slot] <= r_req_key;
        end
        if (i_cmd.commit && r_req_put) begin
            r_values[r_l_slot] <= r_req_value;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_hit   <= r_l_hit;
            r_out_value <= r_l_rdv;
        end
    end

    assign o_hit        = r_out_hit;
    assign o_read_value = r_out_value;

endmodule

[hdl/lru_key_value_cache.sv]
// lru key/value cache, fully associative, least recent entry replaced
// sequence: key compare state, then recency rank update state, then the result register
// overlap: the next item is accepted as the last one commits its update;
//   a waiting result stalls the update
// reset: synchronous active low; store empty, capacity 16, no result pending
module lru_key_value_cache (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic        [lkvc_pkg::CAP_W-1:0]   i_cfg_data,
    input  logic                                i_req_valid,
    output logic                                o_req_ready,
    input  logic                                i_req_type,
    input  logic signed [lkvc_pkg::DATA_W-1:0]  i_req_key,
    input  logic signed [lkvc_pkg::DATA_W-1:0]  i_req_value,
    output logic                                o_res_valid,
    input  logic                                i_res_ready,
    output logic                                o_hit,
    output logic signed [lkvc_pkg::DATA_W-1:0]  o_read_value
);

    lkvc_pkg::t_lkvc_cmd cmd;

    // sequencing
    lkvc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req_valid),
        .o_req_ready (o_req_ready),
        .o_res_valid (o_res_valid),
        .i_res_ready (i_res_ready),
        .o_cmd       (cmd)
    );

    // store, lookup and update
    lkvc_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_data   (i_cfg_data),
        .i_req_type   (i_req_type),
        .i_req_key    (i_req_key),
        .i_req_value  (i_req_value),
        .o_hit        (o_hit),
        .o_read_value (o_read_value)
    );

endmodule
